@@ hw/rtl/bounded_list_insert_remove_compact_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the bounded list block
// Shared property forms; each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_LIST_INSERT_REMOVE_COMPACT_DEFINES_SVH
`define BOUNDED_LIST_INSERT_REMOVE_COMPACT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLIRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded list assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BLIRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded list assertion failed");

`endif

@@ hw/rtl/blirc_pkg.sv @@
// ---------------------------------------------------------------------------
// blirc_pkg
// Types and constants shared by the bounded list modules.
// ---------------------------------------------------------------------------
`default_nettype none

package blirc_pkg;

  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_VAL_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bounded_list_insert_remove_compact.sv @@
// A request taken while idle runs a single pass of the shared compare unit over the
// occupied entries, one entry per cycle (no pass on an empty list), then a finishing
// step loads the result register when it is free; no new request is taken until then.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// stored values need no reset since only occupied entries are ever compared.
// ---------------------------------------------------------------------------
// bounded_list_insert_remove_compact
// Ordered fixed-capacity list with insert, remove-all-matches, lookup, clear.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_list_insert_remove_compact import blirc_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [IN_VAL_W-1:0] in_value,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [STATUS_W-1:0] out_status,
  output      logic                out_found,
  output      logic [COUNT_W-1:0]  out_removed_count,
  output      logic [COUNT_W-1:0]  out_entry_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Sequencer and datapath registers.
  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]       occupied_r, occupied_nxt;
  logic [CNT_W-1:0]       rd_r, rd_nxt;     // index of the entry now in rdata
  logic [CNT_W-1:0]       wr_r, wr_nxt;     // next compaction slot
  logic                   found_r, found_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic                   ofound_r, ofound_nxt;
  logic [COUNT_W-1:0]     removed_r, removed_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;

  // Storage port signals.
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]       mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic                   accept;
  logic                   advance;
  logic                   match;
  logic                   last_entry;
  logic [63:0]            in_wide;
  logic [31:0]            removed_wide;
  logic [31:0]            count_wide;

  blirc_store #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // The request value is cut down to the stored width before any use.
  assign in_wide = 64'(in_value);

  // A new request is taken only while the sequencer is idle.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // The finishing step waits until the result register is free or being taken.
  assign advance  = !out_valid_r || !out_stall;

  // Shared compare unit: one occupied entry is checked per scan cycle.
  assign match      = (mem_rdata == val_r);
  assign last_entry = (rd_r == (occupied_r - CNT_W'(1)));

  // The read runs one entry ahead of the compare, so the stream stays gapless.
  // While idle, entry 0 is prefetched for the next scan.
  always_comb begin
    if (state_r == S_SCAN) begin
      mem_raddr = IDX_W'(rd_r + CNT_W'(1));
    end else begin
      mem_raddr = '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (occupied_r == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_entry) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (advance) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, storage writes and the result register.
  always_comb begin
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    occupied_nxt  = occupied_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    ofound_nxt    = ofound_r;
    removed_nxt   = removed_r;
    count_nxt     = count_r;
    mem_we        = 1'b0;
    mem_waddr     = IDX_W'(wr_r);
    mem_wdata     = mem_rdata;
    removed_wide  = '0;
    count_wide    = 32'(occupied_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = cmd_t'(in_command);
          val_nxt   = in_wide[VALUE_WIDTH-1:0];
          rd_nxt    = '0;
          wr_nxt    = '0;
          found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        // A remove copies each survivor down to the next free slot; the write
        // slot never passes the entry being read, so no unread entry is lost.
        if (match) begin
          found_nxt = 1'b1;
        end else if (cmd_r == CMD_REMOVE) begin
          mem_we = 1'b1;
          wr_nxt = wr_r + CNT_W'(1);
        end
        rd_nxt = rd_r + CNT_W'(1);
      end
      S_FINISH: begin
        if (advance) begin
          status_nxt = ST_OK;
          case (cmd_r)
            CMD_INSERT: begin
              if (occupied_r == CAP_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = IDX_W'(occupied_r);
                mem_wdata    = val_r;
                occupied_nxt = occupied_r + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (occupied_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                removed_wide = 32'(occupied_r - wr_r);
                occupied_nxt = wr_r;
              end
            end
            CMD_LOOKUP: begin
              occupied_nxt = occupied_r;
            end
            CMD_CLEAR: begin
              occupied_nxt = '0;
            end
            default: occupied_nxt = occupied_r;
          endcase
          count_wide    = 32'(occupied_nxt);
          out_valid_nxt = 1'b1;
          ofound_nxt    = found_r;
          removed_nxt   = removed_wide[COUNT_W-1:0];
          count_nxt     = count_wide[COUNT_W-1:0];
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occupied_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occupied_r  <= occupied_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    found_r   <= found_nxt;
    status_r  <= status_nxt;
    ofound_r  <= ofound_nxt;
    removed_r <= removed_nxt;
    count_r   <= count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found         = ofound_r;
  assign out_removed_count = removed_r;
  assign out_entry_count   = count_r;

endmodule

`default_nettype wire

@@ hw/rtl/blirc_store.sv @@
// ---------------------------------------------------------------------------
// blirc_store
// List storage: one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module blirc_store import blirc_pkg::*; #(
  parameter int CAPACITY    = DEF_CAPACITY,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [IDX_W-1:0]       wr_addr,
  input  wire logic [VALUE_WIDTH-1:0] wr_data,
  input  wire logic [IDX_W-1:0]       rd_addr,
  output      logic [VALUE_WIDTH-1:0] rd_data
);

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is registered; a read in the cycle of a write to the same
  // address returns the old contents.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/blirc_checker.sv @@
// ---------------------------------------------------------------------------
// blirc_checker
// Port-level checks for the bounded list, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bounded_list_insert_remove_compact_defines.svh"

module blirc_checker import blirc_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic                out_found,
  input wire logic [COUNT_W-1:0]  out_removed_count,
  input wire logic [COUNT_W-1:0]  out_entry_count
);

  localparam logic [COUNT_W-1:0] CAP_LO = COUNT_W'(CAPACITY);

  logic in_acc;
  logic out_held;
  logic full_report;
  logic empty_report;
  logic empty_clean;

  assign in_acc       = in_valid && !in_stall;
  assign out_held     = out_valid && out_stall;
  assign full_report  = out_valid && (out_status == ST_FULL);
  assign empty_report = out_valid && (out_status == ST_EMPTY);
  assign empty_clean  = (out_entry_count == '0) && (out_removed_count == '0) && !out_found;

  // A pending result is not withdrawn while the receiver stalls.
  `BLIRC_ASSERT_NEXT(a_out_hold, out_held, out_valid)

  // After taking a request the block is busy in the following cycle.
  `BLIRC_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)

  // A full report leaves the list at capacity.
  `BLIRC_ASSERT_SAME(a_full_count, full_report, out_entry_count == CAP_LO)

  // An empty report removes nothing and finds nothing.
  `BLIRC_ASSERT_SAME(a_empty_result, empty_report, empty_clean)

endmodule

bind bounded_list_insert_remove_compact blirc_checker #(
  .CAPACITY (CAPACITY)
) u_blirc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_found         (out_found),
  .out_removed_count (out_removed_count),
  .out_entry_count   (out_entry_count)
);

`default_nettype wire

@@ bench/tb_bounded_list_insert_remove_compact.sv @@
// ---------------------------------------------------------------------------
// tb_bounded_list_insert_remove_compact
// Self-checking bench for the bounded list: directed corner requests, then
// random mixed traffic, back-to-back traffic and fill-and-purge rounds, with
// every result checked against a behavioral copy of the list kept here.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_bounded_list_insert_remove_compact;
  import blirc_pkg::*;

  localparam int LIST_CAPACITY = DEF_CAPACITY;
  localparam int HALF_PERIOD   = 6;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  // Longest request is one that scans a full list.
  localparam int SETTLE_CYCLES = 2 * (LIST_CAPACITY + 2);

  // One result as the block reports it.
  typedef struct {
    status_t             status;
    logic                found;
    logic [COUNT_W-1:0]  removed;
    logic [COUNT_W-1:0]  entries;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command;
  logic [IN_VAL_W-1:0] in_value;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [COUNT_W-1:0]  out_removed_count;
  logic [COUNT_W-1:0]  out_entry_count;

  // Behavioral copy of the list contents, oldest entry first.
  logic [IN_VAL_W-1:0] held_values[$];
  // Results predicted for accepted requests, in acceptance order.
  list_result_t        awaited_results[$];
  // A small set of values reused so that duplicates and matches are common.
  logic [IN_VAL_W-1:0] value_pool[6];

  int  mismatch_count = 0;
  int  results_seen   = 0;
  // When set, neither side inserts idle cycles.
  bit  steady_traffic = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  bounded_list_insert_remove_compact u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_removed_count (out_removed_count),
    .out_entry_count   (out_entry_count)
  );

  // -------------------------------------------------------------------------
  // List predictor. The found flag always reflects the contents before the
  // request. Remove drops every match and keeps the survivors in order; the
  // removed count is the difference in size. Clear empties the list but
  // still reports whether the value had been held.
  // -------------------------------------------------------------------------
  function automatic list_result_t apply_list_command(cmd_t cmd,
                                                      logic [IN_VAL_W-1:0] value);
    list_result_t        res;
    logic [IN_VAL_W-1:0] survivors[$];
    res.status  = ST_OK;
    res.found   = 1'b0;
    res.removed = '0;
    foreach (held_values[i]) begin
      if (held_values[i] == value) res.found = 1'b1;
    end
    case (cmd)
      CMD_INSERT: begin
        if (held_values.size() < LIST_CAPACITY) held_values.push_back(value);
        else res.status = ST_FULL;
      end
      CMD_REMOVE: begin
        if (held_values.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          foreach (held_values[i]) begin
            if (held_values[i] != value) survivors.push_back(held_values[i]);
          end
          res.removed = COUNT_W'(held_values.size() - survivors.size());
          held_values = survivors;
        end
      end
      CMD_LOOKUP: begin
      end
      CMD_CLEAR: begin
        held_values.delete();
      end
    endcase
    res.entries = COUNT_W'(held_values.size());
    return res;
  endfunction

  // Idle cycles before the next request or before taking the next result.
  // Zero is favored so that back-to-back handshakes are frequent too.
  function automatic int idle_draw();
    if (steady_traffic || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [IN_VAL_W-1:0] pick_value();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return value_pool[$urandom_range(0, 5)];
  endfunction

  // The pool always keeps both value extremes within reach.
  task automatic refresh_pool();
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 6; i++) value_pool[i] = $urandom;
  endtask

  function automatic cmd_t pick_command(int insert_pct, int remove_pct, int clear_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) return CMD_INSERT;
    if (roll < insert_pct + remove_pct) return CMD_REMOVE;
    if (roll < insert_pct + remove_pct + clear_pct) return CMD_CLEAR;
    return CMD_LOOKUP;
  endfunction

  // -------------------------------------------------------------------------
  // Request driver. Valid is left high after acceptance so that a following
  // request with no gap needs only one assignment in that time step; it is
  // lowered either by the next gap or by end_burst.
  // -------------------------------------------------------------------------
  task automatic send_request(input cmd_t cmd, input logic [IN_VAL_W-1:0] value);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= value;
    // The request is taken at the first edge that sees stall low.
    do @(posedge clk); while (in_stall !== 1'b0);
    awaited_results.push_back(apply_list_command(cmd, value));
  endtask

  // Must be called in the time step of the last acceptance.
  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender holds off until every outstanding result has been taken.
  task automatic drain_results();
    end_burst();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Result side. The stall process draws a wait for each result, and the
  // checker compares every accepted result with the oldest prediction.
  // -------------------------------------------------------------------------
  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with no request outstanding: status %0d found %0b",
                   results_seen, out_status, out_found);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status || out_found !== want.found ||
            out_removed_count !== want.removed || out_entry_count !== want.entries) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d mismatch: expected status %0d found %0b removed %0d ",
                      "count %0d, got status %0d found %0b removed %0d count %0d"},
                     results_seen, want.status, want.found, want.removed, want.entries,
                     out_status, out_found, out_removed_count, out_entry_count);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Corner cases: requests on an empty list, duplicates, removal of all
  // copies, clear reporting a held value, a full list refusing an insert,
  // a remove with no match, and a remove that empties a full list.
  task automatic test_corner_requests();
    logic [IN_VAL_W-1:0] fill_value;
    fill_value = 32'h8000_0001;
    send_request(CMD_LOOKUP, '0);
    send_request(CMD_REMOVE, 32'h0000_0005);
    send_request(CMD_INSERT, '0);
    send_request(CMD_INSERT, '1);
    send_request(CMD_INSERT, '0);
    send_request(CMD_REMOVE, '0);
    send_request(CMD_CLEAR, '1);
    repeat (LIST_CAPACITY) send_request(CMD_INSERT, fill_value);
    send_request(CMD_INSERT, 32'h7FFF_FFFE);
    send_request(CMD_REMOVE, 32'h0000_0001);
    send_request(CMD_REMOVE, fill_value);
    // Hold the sender until the block has answered everything so far.
    drain_results();
  endtask

  // Mixed traffic over a value pool, with the clear rate changed between
  // stretches so that the list is sometimes kept short and sometimes full.
  task automatic test_mixed_traffic(input int count);
    int clear_pct;
    clear_pct = 10;
    for (int i = 0; i < count; i++) begin
      if (i % 125 == 0) begin
        refresh_pool();
        clear_pct      = ($urandom_range(0, 1) == 0) ? 2 : 10;
        steady_traffic = ($urandom_range(0, 3) == 0);
      end
      if (i == count / 2) drain_results();
      send_request(pick_command(45, 20, clear_pct), pick_value());
    end
    steady_traffic = 1'b0;
    end_burst();
  endtask

  // Requests with no idle cycles on either side.
  task automatic test_back_to_back(input int count);
    steady_traffic = 1'b1;
    refresh_pool();
    for (int i = 0; i < count; i++) send_request(pick_command(40, 25, 5), pick_value());
    steady_traffic = 1'b0;
    end_burst();
  endtask

  // Rounds that clear the list, fill it (sometimes past capacity) from two
  // values with a little noise, then purge each value and probe again.
  task automatic test_fill_and_purge(input int rounds);
    logic [IN_VAL_W-1:0] first_value;
    logic [IN_VAL_W-1:0] second_value;
    int                  fill;
    for (int r = 0; r < rounds; r++) begin
      refresh_pool();
      first_value  = pick_value();
      second_value = pick_value();
      send_request(CMD_CLEAR, pick_value());
      fill = $urandom_range(1, LIST_CAPACITY + 2);
      for (int k = 0; k < fill; k++) begin
        case ($urandom_range(0, 9))
          0:       send_request(CMD_INSERT, $urandom);
          1, 2, 3: send_request(CMD_INSERT, second_value);
          default: send_request(CMD_INSERT, first_value);
        endcase
      end
      send_request(CMD_LOOKUP, first_value);
      send_request(CMD_REMOVE, first_value);
      send_request(CMD_REMOVE, first_value);
      send_request(CMD_LOOKUP, second_value);
      send_request(CMD_REMOVE, second_value);
      if ($urandom_range(0, 1) == 0) send_request(CMD_REMOVE, pick_value());
    end
    end_burst();
  endtask

  // -------------------------------------------------------------------------
  // Main sequence: reset once, run the tests, wait for the last results.
  // -------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_INSERT;
    in_value   = '0;
    refresh_pool();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_requests();
    test_mixed_traffic(1000);
    test_back_to_back(300);
    test_fill_and_purge(24);

    while (awaited_results.size() != 0) @(posedge clk);
    // Allow any stray result to surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("bounded_list_insert_remove_compact verification clean");
    end else begin
      $display("bounded_list_insert_remove_compact verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("bounded_list_insert_remove_compact verification failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/blirc_pkg.sv
hw/rtl/blirc_store.sv
hw/rtl/bounded_list_insert_remove_compact.sv
hw/rtl/blirc_checker.sv
bench/tb_bounded_list_insert_remove_compact.sv
